// File: rtl/stl_pkg.sv
// Package for the source token lexer: token kinds, lexer modes, word flags,
// and the token record passed from the scanner to the output queue.
// No dependencies.
package stl_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LINE_BITS   = 24;
  localparam int COLUMN_BITS = 16;

  typedef enum logic [4:0] {
    K_END      = 5'd0,
    K_SEMI     = 5'd1,
    K_NEWLINE  = 5'd2,
    K_SPACE    = 5'd3,
    K_LPAREN   = 5'd4,
    K_RPAREN   = 5'd5,
    K_LBRACE   = 5'd6,
    K_RBRACE   = 5'd7,
    K_LBRACKET = 5'd8,
    K_RBRACKET = 5'd9,
    K_COMMA    = 5'd10,
    K_BSLASH   = 5'd11,
    K_STRING   = 5'd12,
    K_COMMENT  = 5'd13,
    K_SYMBOL   = 5'd14,
    K_MESSAGE  = 5'd15,
    K_OPERATOR = 5'd16,
    K_INTEGER  = 5'd17,
    K_NAME     = 5'd18,
    K_ERROR    = 5'd19
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_SPACE   = 3'd1,
    M_STRING  = 3'd2,
    M_WORD    = 3'd3,
    M_COMMENT = 3'd4
  } mode_t;

  // Keyword tracker codes
  localparam logic [1:0] KW_NONE = 2'd0;
  localparam logic [1:0] KW_AND  = 2'd1;
  localparam logic [1:0] KW_OR   = 2'd2;
  localparam logic [1:0] KW_NOT  = 2'd3;

  localparam logic [1:0] CFG_CONDENSE = 2'd0;

  // Token record; value is the finished integer payload
  typedef struct packed {
    kind_t                    kind;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [OFFSET_BITS-1:0]   end_offset;
    logic [LINE_BITS-1:0]     start_line;
    logic [COLUMN_BITS-1:0]   start_column;
    logic signed [63:0]       value;
    logic                     overflow;
    logic                     last;
  } token_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return !((c == 8'h3B) || (c == 8'h0A) || is_blank(c) || (c == 8'h28) ||
             (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) || (c == 8'h5B) ||
             (c == 8'h5D) || (c == 8'h22) || (c == 8'h2C));
  endfunction

  function automatic logic is_op_byte(input logic [7:0] c);
    logic r;
    case (c)
      8'h60, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h2D, 8'h2B, 8'h3D, 8'h5C, 8'h7C, 8'h22,
      8'h27, 8'h2C, 8'h3C, 8'h2E, 8'h3E, 8'h2F, 8'h3F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Expected keyword character at a position (0 when beyond its length)
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      KW_AND:  r = (idx == 2'd1) ? 8'h6E : (idx == 2'd2) ? 8'h64 : 8'h00;
      KW_OR:   r = (idx == 2'd1) ? 8'h72 : 8'h00;
      KW_NOT:  r = (idx == 2'd1) ? 8'h6F : (idx == 2'd2) ? 8'h74 : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] kw_len(input logic [1:0] k);
    logic [1:0] r;
    case (k)
      KW_AND:  r = 2'd3;
      KW_OR:   r = 2'd2;
      KW_NOT:  r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/stl_scan.sv
// Front part of the lexer: consumes one byte per cycle while take is high,
// tracks positions and word flags, and emits up to two token records per byte.
// Depends on stl_pkg.
module stl_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      char_byte,
  input  logic            is_end,
  input  logic            condense,
  output logic            tok0_valid,
  output stl_pkg::token_t tok0,
  output logic            tok1_valid,
  output stl_pkg::token_t tok1
);
  import stl_pkg::*;

  localparam logic [63:0] LIM63 = 64'h8000_0000_0000_0000;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] cur_offset, cur_offset_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0] cur_column, cur_column_next;
  logic [OFFSET_BITS-1:0] ts_offset, ts_offset_next;
  logic [LINE_BITS-1:0]   ts_line, ts_line_next;
  logic [COLUMN_BITS-1:0] ts_column, ts_column_next;
  logic                   f_allhash, f_colon, f_first, f_last, f_allop, f_int, f_neg;
  logic                   n_allhash, n_colon, n_first, n_last, n_allop, n_int, n_neg;
  logic [1:0]             wlen, wlen_next;
  logic [1:0]             kwt, kwt_next;
  logic [63:0]            accum, accum_next;
  logic                   sat, sat_next;
  logic                   after_nl, after_nl_next;

  logic                   e0, e1;
  token_t                 t0, t1;

  // Digit step helpers: accum*10 + d with saturation at 2^63
  logic        is_digit;
  logic [3:0]  dig;
  logic [67:0] prod;
  logic        ovf_step;
  assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign dig      = char_byte[3:0];

  // Emit helper state, evaluated in the combinational block
  always_comb begin
    logic        done;
    logic        em;
    kind_t       kd;
    logic [63:0] val;
    logic        ovf;
    logic [63:0] a_base;
    logic        s_base;
    logic [1:0]  idx;
    logic        drop;
    logic        an_mid;

    mode_next       = mode;
    cur_offset_next = cur_offset;
    cur_line_next   = cur_line;
    cur_column_next = cur_column;
    ts_offset_next  = ts_offset;
    ts_line_next    = ts_line;
    ts_column_next  = ts_column;
    {n_allhash, n_colon, n_first, n_last, n_allop, n_int, n_neg} =
      {f_allhash, f_colon, f_first, f_last, f_allop, f_int, f_neg};
    wlen_next     = wlen;
    kwt_next      = kwt;
    accum_next    = accum;
    sat_next      = sat;
    after_nl_next = after_nl;
    e0 = 1'b0;
    e1 = 1'b0;
    t0 = '0;
    t1 = '0;
    done   = 1'b0;
    em     = 1'b0;
    kd     = K_END;
    val    = '0;
    ovf    = 1'b0;
    a_base = '0;
    s_base = 1'b0;
    idx    = 2'd0;
    drop   = 1'b0;
    an_mid = after_nl;
    prod   = '0;
    ovf_step = 1'b0;

    // Pending token that the current byte closes: kind in kd, emitted first
    if (is_end) begin
      case (mode)
        M_SPACE:   begin em = 1'b1; kd = K_SPACE; end
        M_STRING:  begin em = 1'b1; kd = K_ERROR; end
        M_COMMENT: begin em = 1'b1; kd = K_COMMENT; end
        M_WORD:    em = 1'b1;
        default:   em = 1'b0;
      endcase
    end else begin
      case (mode)
        M_SPACE: begin
          if (!is_blank(char_byte)) begin em = 1'b1; kd = K_SPACE; end
        end
        M_STRING: begin
          if (char_byte == 8'h22) begin em = 1'b1; kd = K_STRING; end
        end
        M_WORD: begin
          if (!is_word_byte(char_byte) && !(f_allhash && char_byte != 8'h0A)) em = 1'b1;
        end
        M_COMMENT: begin
          if (char_byte == 8'h0A) begin em = 1'b1; kd = K_COMMENT; end
        end
        default: em = 1'b0;
      endcase
    end

    // Classify a finished word
    if (em && mode == M_WORD) begin
      if (f_allhash) kd = K_COMMENT;
      else if (f_colon) begin
        if (wlen == 2'd1) kd = K_ERROR;
        else if (f_first && !(wlen == 2'd2 && f_first && f_last)) kd = K_SYMBOL;
        else if (f_last) kd = K_MESSAGE;
        else kd = K_ERROR;
      end else if (f_allop) kd = K_OPERATOR;
      else if (kwt != KW_NONE && wlen == kw_len(kwt)) kd = K_OPERATOR;
      else if (f_int) begin
        kd  = K_INTEGER;
        ovf = sat;
        if (f_neg) val = 64'd0 - accum;
        else if (accum > LIM63 - 64'd1) begin
          val = LIM63 - 64'd1;
          ovf = 1'b1;
        end else val = accum;
      end else kd = K_NAME;
    end

    // First-slot token; the end offset is the current offset, or one past it
    // for a closing quote that is consumed with the token
    if (em) begin
      if (kd == K_SPACE || kd == K_COMMENT) drop = condense;
      else if (kd == K_NEWLINE) drop = condense && after_nl;
      if (!drop) begin
        e0 = 1'b1;
        t0.kind         = kd;
        t0.start_offset = ts_offset;
        t0.end_offset   = (mode == M_STRING && !is_end) ? cur_offset + 1'b1 : cur_offset;
        t0.start_line   = ts_line;
        t0.start_column = ts_column;
        t0.value        = val;
        t0.overflow     = ovf;
      end
      // Whitespace and comments keep the newline history, other tokens clear it
      an_mid        = (kd == K_SPACE || kd == K_COMMENT) ? after_nl : 1'b0;
      after_nl_next = an_mid;
    end

    if (is_end) begin
      // END token, then return to the start state
      e1 = 1'b1;
      t1.kind         = K_END;
      t1.start_offset = cur_offset;
      t1.end_offset   = cur_offset;
      t1.start_line   = cur_line;
      t1.start_column = cur_column;
      mode_next       = M_IDLE;
      cur_offset_next = '0;
      cur_line_next   = '0;
      cur_column_next = '0;
      ts_offset_next  = '0;
      ts_line_next    = '0;
      ts_column_next  = '0;
      {n_allhash, n_colon, n_first, n_last, n_allop, n_int, n_neg} = '0;
      wlen_next     = '0;
      kwt_next      = '0;
      accum_next    = '0;
      sat_next      = 1'b0;
      after_nl_next = 1'b0;
    end else begin
      // Advance position for every byte
      if (char_byte == 8'h0A) begin
        if (cur_line != '1) cur_line_next = cur_line + 1'b1;
        cur_column_next = '0;
      end else if (cur_column != '1) begin
        cur_column_next = cur_column + 1'b1;
      end
      cur_offset_next = cur_offset + 1'b1;

      case (mode)
        M_SPACE:   begin done = !em; if (em) mode_next = M_IDLE; end
        M_STRING:  begin done = 1'b1; if (em) mode_next = M_IDLE; end
        M_COMMENT: begin done = !em; if (em) mode_next = M_IDLE; end
        M_WORD: begin
          if (is_word_byte(char_byte)) done = 1'b1;
          else if (f_allhash) begin
            mode_next = em ? M_IDLE : M_COMMENT;
            done = !em;
          end else mode_next = M_IDLE;
        end
        default: done = 1'b0;
      endcase

      // Word byte: added to the running word
      if ((mode == M_WORD && is_word_byte(char_byte)) ||
          (!done && is_word_byte(char_byte) && char_byte != 8'h5C)) begin
        if (mode == M_WORD && is_word_byte(char_byte)) idx = wlen;
        else idx = 2'd0;
        if (idx == 2'd0) begin
          {n_allhash, n_allop, n_int} = 3'b111;
          {n_colon, n_first, n_last, n_neg} = '0;
          a_base = '0;
          s_base = 1'b0;
          kwt_next = (char_byte == 8'h61) ? KW_AND : (char_byte == 8'h6F) ? KW_OR :
                     (char_byte == 8'h6E) ? KW_NOT : KW_NONE;
          if (char_byte == 8'h3A) n_first = 1'b1;
          if (char_byte == 8'h2D) n_neg = 1'b1;
        end else begin
          a_base = accum;
          s_base = sat;
          if (kwt == KW_NONE || idx >= kw_len(kwt) || kw_char(kwt, idx) != char_byte)
            kwt_next = KW_NONE;
        end
        if (char_byte != 8'h23) n_allhash = 1'b0;
        if (char_byte == 8'h3A) begin n_colon = 1'b1; n_last = 1'b1; end
        else n_last = 1'b0;
        if (!is_op_byte(char_byte)) n_allop = 1'b0;
        if (!(is_digit || (idx == 2'd0 && (char_byte == 8'h2B || char_byte == 8'h2D))))
          n_int = 1'b0;
        accum_next = a_base;
        sat_next   = s_base;
        if (is_digit && n_int) begin
          // times ten as two shifted copies
          prod = ({4'd0, a_base} << 3) + ({4'd0, a_base} << 1) + {64'd0, dig};
          ovf_step = s_base || (prod > {4'd0, LIM63});
          if (ovf_step) begin
            accum_next = LIM63;
            sat_next   = 1'b1;
          end else accum_next = prod[63:0];
        end
        wlen_next = (idx == 2'd3) ? 2'd3 : idx + 2'd1;
      end

      // Byte that starts a new token
      if (!done) begin
        ts_offset_next = cur_offset;
        ts_line_next   = cur_line;
        ts_column_next = cur_column;
        kd = K_END;
        case (char_byte)
          8'h3B: kd = K_SEMI;
          8'h0A: kd = K_NEWLINE;
          8'h28: kd = K_LPAREN;
          8'h29: kd = K_RPAREN;
          8'h7B: kd = K_LBRACE;
          8'h7D: kd = K_RBRACE;
          8'h5B: kd = K_LBRACKET;
          8'h5D: kd = K_RBRACKET;
          8'h2C: kd = K_COMMA;
          8'h5C: kd = K_BSLASH;
          8'h20, 8'h09, 8'h0D: mode_next = M_SPACE;
          8'h22: mode_next = M_STRING;
          default: mode_next = M_WORD;
        endcase
        if (kd == K_BSLASH) begin
          // backslash is a word byte but starts its own token
          {n_allhash, n_colon, n_first, n_last, n_allop, n_int, n_neg} =
            {f_allhash, f_colon, f_first, f_last, f_allop, f_int, f_neg};
          wlen_next  = wlen;
          kwt_next   = kwt;
          accum_next = accum;
          sat_next   = sat;
        end
        if (kd != K_END) begin
          drop = (kd == K_NEWLINE) && condense && an_mid;
          if (kd == K_NEWLINE) after_nl_next = 1'b1;
          else after_nl_next = 1'b0;
          if (!drop) begin
            e1 = 1'b1;
            t1.kind         = kd;
            t1.start_offset = cur_offset;
            t1.end_offset   = cur_offset + 1'b1;
            t1.start_line   = cur_line;
            t1.start_column = cur_column;
          end
        end
      end
    end

    // Mark the final token of this byte
    if (e1) t1.last = 1'b1;
    else t0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      cur_offset <= '0;
      cur_line   <= '0;
      cur_column <= '0;
      ts_offset  <= '0;
      ts_line    <= '0;
      ts_column  <= '0;
      {f_allhash, f_colon, f_first, f_last, f_allop, f_int, f_neg} <= '0;
      wlen       <= '0;
      kwt        <= '0;
      accum      <= '0;
      sat        <= 1'b0;
      after_nl   <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      cur_offset <= cur_offset_next;
      cur_line   <= cur_line_next;
      cur_column <= cur_column_next;
      ts_offset  <= ts_offset_next;
      ts_line    <= ts_line_next;
      ts_column  <= ts_column_next;
      {f_allhash, f_colon, f_first, f_last, f_allop, f_int, f_neg} <=
        {n_allhash, n_colon, n_first, n_last, n_allop, n_int, n_neg};
      wlen       <= wlen_next;
      kwt        <= kwt_next;
      accum      <= accum_next;
      sat        <= sat_next;
      after_nl   <= after_nl_next;
    end
  end

  assign tok0_valid = take && e0;
  assign tok0       = t0;
  assign tok1_valid = take && e1;
  assign tok1       = t1;

endmodule

// File: rtl/stl_queue.sv
// Token queue between the scanner and the output port: takes up to two tokens
// per cycle, delivers one while rd_take is high. Depends on stl_pkg.
module stl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr0,
  input  stl_pkg::token_t wd0,
  input  logic            wr1,
  input  stl_pkg::token_t wd1,
  output logic            room,
  output logic            rd_valid,
  output stl_pkg::token_t rd_data,
  input  logic            rd_take
);
  import stl_pkg::*;

  localparam int DEPTH = 4;

  token_t     slots [DEPTH];
  logic [1:0] wptr, rptr;
  logic [2:0] count, count_next;
  logic [1:0] wcnt;

  assign wcnt       = {1'b0, wr0} + {1'b0, wr1};
  assign count_next = count + {1'b0, wcnt} - {2'd0, rd_take};
  // Two free entries guarantee space for any byte's tokens
  assign room       = (count <= 3'd2);
  assign rd_valid   = (count != 3'd0);
  assign rd_data    = slots[rptr];

  // Write the first present token, then the second
  always_ff @(posedge clk) begin
    if (wr0) slots[wptr] <= wd0;
    if (wr1) slots[wr0 ? wptr + 2'd1 : wptr] <= wd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + wcnt;
      rptr  <= rptr + {1'b0, rd_take};
      count <= count_next;
    end
  end

  // Never overrun or underrun
  assert property (@(posedge clk) disable iff (rst) rd_take |-> count != 3'd0)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (rst) count <= 3'(DEPTH))
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (rst) (wr0 || wr1) |-> room)
    else $error("write without room");

endmodule

// File: rtl/source_token_lexer_core.sv
// Top level of the source token lexer: config register, byte scanner and
// output token queue. Depends on stl_pkg, stl_scan, stl_queue.
//
//  channel   direction  handshake        payload
//  input     in         valid / stall    char_byte, is_end
//  output    out        out_valid/_stall token fields, last_of_run
//  config    in         APB write/read   condense_enable at 0x0
//
// One byte is accepted per cycle while the queue has room; its tokens leave
// the queue in the next cycle at the earliest, one per cycle while out_stall
// is low. The four-entry token queue sets the rate: a byte is taken while two
// entries are free, so bytes that keep yielding two tokens, or a stalled
// output, fill the queue and stall the input until it drains to two entries.
// Reset is synchronous; it clears the lexer state and sets condense to 1.
module source_token_lexer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  char_byte,
  input  logic        is_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [31:0] end_offset,
  output logic [23:0] start_line,
  output logic [15:0] start_column,
  output logic signed [63:0] int_value,
  output logic        int_overflow,
  output logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stl_pkg::*;

  logic   condense;
  logic   take, room;
  logic   w0, w1;
  token_t t0, t1, rd;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) condense <= 1'b1;
    else if (psel && penable && pwrite && paddr == CFG_CONDENSE[0])
      condense <= pwdata[0];
  end
  assign prdata = (paddr == CFG_CONDENSE[0]) ? {31'd0, condense} : 32'd0;

  assign stall = !room;
  assign take  = valid && room;

  stl_scan u_scan (
    .clk, .rst, .take, .char_byte, .is_end, .condense,
    .tok0_valid(w0), .tok0(t0), .tok1_valid(w1), .tok1(t1)
  );

  stl_queue u_queue (
    .clk, .rst, .wr0(w0), .wd0(t0), .wr1(w1), .wd1(t1),
    .room, .rd_valid(out_valid), .rd_data(rd), .rd_take(out_valid && !out_stall)
  );

  assign token_kind   = rd.kind;
  assign start_offset = rd.start_offset;
  assign end_offset   = rd.end_offset;
  assign start_line   = rd.start_line;
  assign start_column = rd.start_column;
  assign int_value    = rd.value;
  assign int_overflow = rd.overflow;
  assign last_of_run  = rd.last;

  // Every accepted END produces an output token
  assert property (@(posedge clk) disable iff (rst) (take && is_end) |=> out_valid)
    else $error("END token missing");
  assert property (@(posedge clk) disable iff (rst) take |-> !stall)
    else $error("accept while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output dropped under stall");

endmodule
